### rtl/rfep_pkg.sv
package rfep_pkg;

  localparam int unsigned SumW     = 35;
  localparam int unsigned CntW     = 11;
  localparam int unsigned EnergyW  = 24;
  localparam int unsigned DeltaW   = 32;
  localparam int unsigned AccW     = 37;
  localparam int unsigned OnW      = 8;
  localparam int unsigned OffW     = 10;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] RegFrameLength     = 8'd0;
  localparam logic [CfgIdxW-1:0] RegMotionThreshold = 8'd1;
  localparam logic [CfgIdxW-1:0] RegOnFrames        = 8'd2;
  localparam logic [CfgIdxW-1:0] RegOffFrames       = 8'd3;

  localparam logic [CntW-1:0]   FrameLengthRst     = 11'd128;
  localparam logic [DeltaW-1:0] MotionThresholdRst = 32'd12800000;
  localparam logic [OnW-1:0]    OnFramesRst        = 8'd3;
  localparam logic [OffW-1:0]   OffFramesRst       = 10'd200;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] count;
  } frame_t;

  typedef struct packed {
    logic [DeltaW-1:0] motion_threshold;
    logic [OnW-1:0]    on_frames;
    logic [OffW-1:0]   off_frames;
  } det_cfg_t;

  typedef struct packed {
    logic            start;
    logic [AccW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [AccW-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/rfep_if.sv
interface rfep_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rfep_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] frame_energy;
  logic [31:0] delta_avg;
  logic        presence;

  modport source (output valid, output frame_energy, output delta_avg,
                  output presence, input ready);
  modport sink (input valid, input frame_energy, input delta_avg,
                input presence, output ready);
endinterface

interface rfep_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/radar_frame_energy_presence.sv
// channel  dir  handshake      payload
// in_i     in   valid/ready    sample[SAMPLE_BITS-1:0]
// out_o    out  valid/ready    frame_energy[23:0], delta_avg[31:0], presence
// cfg_i    in   valid/ready    index[7:0], data[31:0] (0 length, 1 threshold, 2 on, 3 off)
//
// Samples are taken one per cycle by the accumulator (one multiply-add per transfer).
// In the back end each frame then passes through the one-bit-per-cycle 37-bit mean divider,
// the divide-by-ten smoothing (shift-and-add, one step per cycle) and the load of the output,
// which waits until the output register is free; the next frame is popped once it is idle again.
// A two-entry frame queue separates the two; the input stalls only while it is full.
// The output register holds a result until taken while the next frame is processed.
// Asynchronous active-low reset; all registers but the queue storage are cleared at once, no clearing pass.
module radar_frame_energy_presence import rfep_pkg::*; #(
  parameter int unsigned MAX_FRAME_SAMPLES = 1024,
  parameter int unsigned SAMPLE_BITS       = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfep_in_if.sink    in_i,
  rfep_out_if.source out_o,
  rfep_cfg_if.sink   cfg_i
);

  localparam int unsigned MaxLen =
      (MAX_FRAME_SAMPLES > ((1 << CntW) - 1)) ? ((1 << CntW) - 1) : MAX_FRAME_SAMPLES;
  localparam logic [CntW-1:0] MaxLenW = CntW'(MaxLen);

  logic [CntW-1:0] frame_len_q;
  logic [CntW-1:0] eff_len;
  det_cfg_t        det_cfg_q;
  logic            q_push, q_pop, q_full, q_empty;
  frame_t          q_wdata, q_rdata;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q                <= FrameLengthRst;
      det_cfg_q.motion_threshold <= MotionThresholdRst;
      det_cfg_q.on_frames        <= OnFramesRst;
      det_cfg_q.off_frames       <= OffFramesRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        RegFrameLength:     frame_len_q                <= cfg_i.data[CntW-1:0];
        RegMotionThreshold: det_cfg_q.motion_threshold <= cfg_i.data[DeltaW-1:0];
        RegOnFrames:        det_cfg_q.on_frames        <= cfg_i.data[OnW-1:0];
        RegOffFrames:       det_cfg_q.off_frames       <= cfg_i.data[OffW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_len_q == '0) begin
      eff_len = CntW'(1);
    end else if (frame_len_q > MaxLenW) begin
      eff_len = MaxLenW;
    end else begin
      eff_len = frame_len_q;
    end
  end

  rfep_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .frame_len_i (eff_len),
    .full_i      (q_full),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  rfep_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  rfep_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rfep_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (det_cfg_q),
    .empty_i   (q_empty),
    .frame_i   (q_rdata),
    .pop_o     (q_pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .out_o     (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("frame pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty && div_req.start)
    else $error("frame popped from empty queue or without divider start");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> $past(div_rsp.busy))
    else $error("divider done without a running division");

endmodule

### rtl/rfep_front.sv
module rfep_front import rfep_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rfep_in_if.sink         in_i,
  input  logic [CntW-1:0] frame_len_i,
  input  logic            full_i,
  output logic            push_o,
  output frame_t          push_data_o
);

  logic [SumW-1:0]          sum_q, sum_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [2*SAMPLE_BITS-1:0] square;
  logic [CntW:0]            cnt_inc;
  logic                     accept;
  logic                     frame_end;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign square     = in_i.sample * in_i.sample;
  assign cnt_inc    = {1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1};
  assign frame_end  = cnt_inc >= {1'b0, frame_len_i};

  always_comb begin
    sum_d = sum_q + SumW'(square);
    cnt_d = cnt_inc[CntW-1:0];
  end

  assign push_o            = accept && frame_end;
  assign push_data_o.sum   = sum_d;
  assign push_data_o.count = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      if (frame_end) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

### rtl/rfep_queue.sv
module rfep_queue import rfep_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_data_i,
  input  logic   pop_i,
  output frame_t pop_data_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  frame_t           mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;

  assign full_o     = fill_q == FillW'(QueueDepth);
  assign empty_o    = fill_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

### rtl/rfep_div.sv
module rfep_div import rfep_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(AccW);
  localparam logic [StepW-1:0] LastStep = StepW'(AccW - 1);

  typedef enum logic {
    DivIdle,
    DivBusy
  } div_state_e;

  div_state_e       state_q;
  logic [AccW-1:0]  quo_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW-1:0]  divisor_q;
  logic [StepW-1:0] step_q;
  logic             done_q;
  logic [CntW:0]    shifted;
  logic             fits;
  logic [CntW:0]    diff;

  assign shifted = {rem_q, quo_q[AccW-1]};
  assign fits    = shifted >= {1'b0, divisor_q};
  assign diff    = shifted - {1'b0, divisor_q};

  assign rsp_o.busy     = state_q == DivBusy;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= DivIdle;
      quo_q     <= '0;
      rem_q     <= '0;
      divisor_q <= '0;
      step_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        DivIdle: begin
          if (req_i.start) begin
            quo_q     <= req_i.dividend;
            rem_q     <= '0;
            divisor_q <= req_i.divisor;
            step_q    <= '0;
            state_q   <= DivBusy;
          end
        end
        DivBusy: begin
          rem_q  <= fits ? diff[CntW-1:0] : shifted[CntW-1:0];
          quo_q  <= {quo_q[AccW-2:0], fits};
          step_q <= step_q + 1'b1;
          if (step_q == LastStep) begin
            done_q  <= 1'b1;
            state_q <= DivIdle;
          end
        end
        default: state_q <= DivIdle;
      endcase
    end
  end

endmodule

### rtl/rfep_back.sv
module rfep_back import rfep_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  det_cfg_t cfg_i,
  input  logic     empty_i,
  input  frame_t   frame_i,
  output logic     pop_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i,
  rfep_out_if.source out_o
);

  typedef enum logic [2:0] {
    BkIdle,
    BkDivEnergy,
    BkSmooth,
    BkDivSmooth,
    BkHold
  } back_state_e;

  back_state_e        state_q;
  logic [EnergyW-1:0] prev_q;
  logic [EnergyW-1:0] energy_q;
  logic [EnergyW-1:0] delta_q;
  logic [DeltaW-1:0]  avg_q;
  logic [OnW-1:0]     above_q, above_d;
  logic [OffW-1:0]    below_q, below_d;
  logic               pres_q, pres_d;
  logic               out_valid_q;
  logic [EnergyW-1:0] out_energy_q;
  logic [DeltaW-1:0]  out_delta_q;
  logic               out_pres_q;
  logic [AccW-1:0]    tenth_q;
  logic [2:0]         tenth_step_q;
  logic [4:0]         tenth_rem_q;

  logic [EnergyW-1:0] energy_new;
  logic [EnergyW-1:0] delta_new;
  logic [AccW-1:0]    acc;
  logic [AccW-1:0]    tenth_shr;
  logic [4:0]         tenth_rem;
  logic [OnW:0]       above_inc;
  logic [OffW:0]      below_inc;
  logic               out_load;

  assign energy_new = div_rsp_i.quotient[EnergyW-1:0];
  assign delta_new  = (energy_new >= prev_q) ? energy_new - prev_q : prev_q - energy_new;
  assign acc = (AccW'(delta_q) << 8) + (AccW'(avg_q) << 3) + AccW'(avg_q);

  // divide by ten: q ~= acc * 0.8 / 8 by shift-and-add, then fix up from the remainder
  always_comb begin
    case (tenth_step_q)
      3'd0:    tenth_shr = tenth_q >> 4;
      3'd1:    tenth_shr = tenth_q >> 8;
      3'd2:    tenth_shr = tenth_q >> 16;
      3'd3:    tenth_shr = tenth_q >> 32;
      default: tenth_shr = '0;
    endcase
  end

  assign tenth_rem = 5'(acc - (tenth_q << 3) - (tenth_q << 1));

  assign pop_o = (state_q == BkIdle) && !empty_i;

  always_comb begin
    div_req_o.start    = pop_o;
    div_req_o.dividend = AccW'(frame_i.sum);
    div_req_o.divisor  = frame_i.count;
  end

  assign above_inc = {1'b0, above_q} + 1'b1;
  assign below_inc = {1'b0, below_q} + 1'b1;

  always_comb begin
    above_d = above_q;
    below_d = below_q;
    pres_d  = pres_q;
    if (avg_q > cfg_i.motion_threshold) begin
      below_d = '0;
      if (above_inc >= {1'b0, cfg_i.on_frames}) begin
        above_d = cfg_i.on_frames;
        pres_d  = 1'b1;
      end else begin
        above_d = above_inc[OnW-1:0];
      end
    end else begin
      above_d = '0;
      if (below_inc >= {1'b0, cfg_i.off_frames}) begin
        below_d = cfg_i.off_frames;
        pres_d  = 1'b0;
      end else begin
        below_d = below_inc[OffW-1:0];
      end
    end
  end

  assign out_load = (state_q == BkHold) && (!out_valid_q || out_o.ready);

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_energy = out_energy_q;
  assign out_o.delta_avg    = out_delta_q;
  assign out_o.presence     = out_pres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BkIdle;
      prev_q       <= '0;
      energy_q     <= '0;
      delta_q      <= '0;
      avg_q        <= '0;
      above_q      <= '0;
      below_q      <= '0;
      pres_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_energy_q <= '0;
      out_delta_q  <= '0;
      out_pres_q   <= 1'b0;
      tenth_q      <= '0;
      tenth_step_q <= '0;
      tenth_rem_q  <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
      case (state_q)
        BkIdle: begin
          if (pop_o) begin
            state_q <= BkDivEnergy;
          end
        end
        BkDivEnergy: begin
          if (div_rsp_i.done) begin
            energy_q <= energy_new;
            delta_q  <= delta_new;
            prev_q   <= energy_new;
            state_q  <= BkSmooth;
          end
        end
        BkSmooth: begin
          tenth_q      <= (acc >> 1) + (acc >> 2);
          tenth_step_q <= '0;
          state_q      <= BkDivSmooth;
        end
        BkDivSmooth: begin
          tenth_step_q <= tenth_step_q + 1'b1;
          if (tenth_step_q < 3'd4) begin
            tenth_q <= tenth_q + tenth_shr;
          end else if (tenth_step_q == 3'd4) begin
            tenth_q <= tenth_q >> 3;
          end else if (tenth_step_q == 3'd5) begin
            tenth_rem_q <= tenth_rem;
          end else begin
            avg_q   <= tenth_q[DeltaW-1:0] + DeltaW'(tenth_rem_q > 5'd9);
            state_q <= BkHold;
          end
        end
        BkHold: begin
          if (out_load) begin
            above_q      <= above_d;
            below_q      <= below_d;
            pres_q       <= pres_d;
            out_energy_q <= energy_q;
            out_delta_q  <= avg_q;
            out_pres_q   <= pres_d;
            state_q      <= BkIdle;
          end
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

endmodule
